// ===== hw/rtl/max_falling_path_sum_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the max_falling_path_sum block
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while the synchronous active-low reset is applied.
// ----------------------------------------------------------------------------
`ifndef MAX_FALLING_PATH_SUM_MACROS_SVH
`define MAX_FALLING_PATH_SUM_MACROS_SVH

// Same-cycle implication.
`define MFPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("max_falling_path_sum: same-cycle check failed");

// Next-cycle implication.
`define MFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("max_falling_path_sum: next-cycle check failed");

`endif

// ===== hw/rtl/mfps_pkg.sv =====
// ----------------------------------------------------------------------------
// mfps_pkg
// Types, widths and defaults shared by the falling path sum block.
// ----------------------------------------------------------------------------
package mfps_pkg;

  localparam int PATH_BITS      = 26;
  localparam int OUT_TDATA_W    = ((PATH_BITS + 7) / 8) * 8;
  localparam int ROW_WIDTH_BITS = 9;
  localparam int ROW_COUNT_BITS = 11;
  localparam int CFG_DATA_W     = (ROW_WIDTH_BITS > ROW_COUNT_BITS) ?
                                  ROW_WIDTH_BITS : ROW_COUNT_BITS;

  localparam int DEF_MAX_COLS     = 256;
  localparam int DEF_MAX_ROWS     = 1024;
  localparam int DEF_ELEMENT_BITS = 16;

  localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = ROW_WIDTH_BITS'(256);
  localparam logic [ROW_COUNT_BITS-1:0] ROW_COUNT_RESET = ROW_COUNT_BITS'(1);

  typedef enum logic [0:0] {
    REG_ROW_WIDTH = 1'b0,
    REG_ROW_COUNT = 1'b1
  } cfg_reg_t;

  typedef logic signed [PATH_BITS-1:0] sum_t;

endpackage

// ===== hw/rtl/mfps_row_buf.sv =====
// ----------------------------------------------------------------------------
// mfps_row_buf
// One-write, one-read row sum memory with a registered read port. A read
// that hits the entry written at the same edge returns the new data.
// ----------------------------------------------------------------------------
module mfps_row_buf #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  mfps_pkg::sum_t      wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output mfps_pkg::sum_t      rd_data
);
  import mfps_pkg::*;

  sum_t mem [0:DEPTH-1];
  sum_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/max_falling_path_sum.sv =====
// Throughput: one element beat per cycle, set by the single read-modify-write of
//   the row sum memory per element; a matrix's last beat stalls on an untaken result.
// Result: the path sum is registered into the output register as the last
//   element of the matrix is accepted.
// Reset: synchronous, active low; clears positions, registers and output
//   valid. The row sum memory is not cleared, since it is written before read.
// ----------------------------------------------------------------------------
// max_falling_path_sum
// Streams a matrix in row-major order and returns its maximum falling path
// sum. Previous-row sums live in one memory updated in place.
// ----------------------------------------------------------------------------
module max_falling_path_sum #(
  parameter int MAX_COLS     = mfps_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS     = mfps_pkg::DEF_MAX_ROWS,
  parameter int ELEMENT_BITS = mfps_pkg::DEF_ELEMENT_BITS,
  parameter int IN_TDATA_W   = ((ELEMENT_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  mfps_pkg::cfg_reg_t                cfg_index,
  input  logic [mfps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_TDATA_W-1:0]             in_tdata,   // [ELEMENT_BITS-1:0] element_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mfps_pkg::OUT_TDATA_W-1:0]  out_tdata   // [25:0] path_sum
);
  import mfps_pkg::*;

  `include "max_falling_path_sum_macros.svh"

  localparam int ADDR_W = $clog2(MAX_COLS > 1 ? MAX_COLS : 2);
  localparam int ROW_W  = $clog2(MAX_ROWS > 1 ? MAX_ROWS : 2);

  logic [ROW_WIDTH_BITS-1:0] row_width_r;
  logic [ROW_COUNT_BITS-1:0] row_count_r;
  logic [ADDR_W-1:0]         col_r;
  logic [ROW_W-1:0]          row_r;
  sum_t                      left_r;
  sum_t                      mid_r;
  sum_t                      first_sum_r;
  sum_t                      max_r;
  logic                      out_valid_r;
  sum_t                      out_sum_r;

  logic [ADDR_W-1:0] cols_m1;
  logic [ROW_W-1:0]  rows_m1;
  logic              last_col;
  logic              last_row;
  logic              in_fire;
  sum_t              right;
  sum_t              elem;
  sum_t              best;
  sum_t              sum;
  sum_t              max_nxt;
  logic [ADDR_W-1:0] rd_addr;

  // Effective sizes: zero acts as one, oversize is clipped to the maximum.
  always_comb begin
    if (row_width_r == '0) begin
      cols_m1 = '0;
    end else if (32'(row_width_r) > MAX_COLS) begin
      cols_m1 = ADDR_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = ADDR_W'(32'(row_width_r) - 32'd1);
    end
    if (row_count_r == '0) begin
      rows_m1 = '0;
    end else if (32'(row_count_r) > MAX_ROWS) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(32'(row_count_r) - 32'd1);
    end
  end

  assign last_col = (col_r == cols_m1);
  assign last_row = (row_r == rows_m1);

  // Only the last element of a matrix produces a result, so the input stalls
  // only when that beat would meet a result that has not been taken.
  assign in_tready = !(out_valid_r && !out_tready && last_col && last_row);
  assign in_fire   = in_tvalid && in_tready;

  assign elem = PATH_BITS'(signed'(in_tdata[ELEMENT_BITS-1:0]));

  always_comb begin
    best = mid_r;
    if ((col_r != '0) && (left_r > best)) begin
      best = left_r;
    end
    if (!last_col && (right > best)) begin
      best = right;
    end
    if (row_r == '0) begin
      sum = elem;
    end else begin
      sum = elem + best;
    end
    if ((col_r == '0) || (sum > max_r)) begin
      max_nxt = sum;
    end else begin
      max_nxt = max_r;
    end
  end

  // The right neighbor of the next element is fetched as this one is taken.
  // At a row end the next row's second entry is fetched instead.
  assign rd_addr = last_col ? ADDR_W'(1) : ADDR_W'(col_r + 2);

  mfps_row_buf #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (ADDR_W)
  ) u_row_buf (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (col_r),
    .wr_data (sum),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RESET;
      row_count_r <= ROW_COUNT_RESET;
      col_r       <= '0;
      row_r       <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_WIDTH: row_width_r <= cfg_wdata[ROW_WIDTH_BITS-1:0];
          REG_ROW_COUNT: row_count_r <= cfg_wdata[ROW_COUNT_BITS-1:0];
          default:       row_width_r <= row_width_r;
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (in_fire) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : ROW_W'(row_r + 1'b1);
        end else begin
          col_r <= ADDR_W'(col_r + 1'b1);
        end
      end
      if (in_fire && last_row) begin
        max_r <= max_nxt;
      end
      if (in_fire && last_col && last_row) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sliding window over the previous row, plus the output sum; payload only, no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (col_r == '0) begin
        first_sum_r <= sum;
      end
      left_r <= mid_r;
      if (last_col) begin
        mid_r <= (col_r == '0) ? sum : first_sum_r;
      end else begin
        mid_r <= right;
      end
      if (last_col && last_row) begin
        out_sum_r <= max_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(unsigned'(out_sum_r));

  `MFPS_ASSERT_NOW(a_col_in_range, clk, rst_n, 1'b1, col_r <= cols_m1)
  `MFPS_ASSERT_NOW(a_no_result_overrun, clk, rst_n, in_fire && last_col && last_row,
                   !out_valid_r || out_tready)
  `MFPS_ASSERT_NOW(a_result_from_last_beat, clk, rst_n, $rose(out_valid_r),
                   $past(in_fire && last_col && last_row))

endmodule
